@@ rtl/bbpid_pkg.sv @@
// Package with the constants and codes of the bang-bang incremental PID heater controller.
package bbpid_pkg;

   localparam int DutyWidth   = 10;
   localparam int ModeWidth   = 2;
   localparam int SampleWidth = 16;
   localparam int CoefWidth   = 8;
   localparam int ErrWidth    = 17;
   localparam int HistWidth   = 9;
   localparam int ProdWidth   = 18;
   localparam int SumWidth    = 20;
   localparam int CsrAddrWidth = 3;
   localparam int CsrDataWidth = 16;

   localparam logic [DutyWidth-1:0] DUTY_MAX = 10'd1000;

   localparam logic [CoefWidth-1:0] RST_COEF_CURRENT = 8'd15;
   localparam logic [CoefWidth-1:0] RST_COEF_LAST    = 8'd5;
   localparam logic [CoefWidth-1:0] RST_COEF_BEFORE  = 8'd30;
   localparam logic [CoefWidth-1:0] RST_BAND         = 8'd1;

   localparam logic [ModeWidth-1:0] MODE_FULL_ON  = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_FULL_OFF = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_PID      = 2'd2;

   localparam logic [CsrAddrWidth-1:0] CSR_SETPOINT     = 3'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_COEF_CURRENT = 3'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_COEF_LAST    = 3'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_COEF_BEFORE  = 3'd3;
   localparam logic [CsrAddrWidth-1:0] CSR_BAND         = 3'd4;

   typedef logic [DutyWidth-1:0] duty_type;

endpackage

@@ rtl/bang_bang_incremental_pid_heater.sv @@
// Top level of the bang-bang incremental PID heater controller.
//
// Each input word carries one signed temperature sample and produces exactly one output word
// with the PWM duty (0 to 1000) and the drive mode. A word is held in the input register
// and then moves to the output register, which presents its result; a new sample is taken
// every cycle unless rsp_tready stalls the output. The error, three 8 by 9 bit multiplies,
// the add and the clamp update the held duty. Errors beyond the band force full on or full
// off and leave the error history untouched. Configuration registers must be written
// through the csr port only while no word is in flight; the block does not enforce it.
module bang_bang_incremental_pid_heater (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: sample[15:0].
   input  logic [bbpid_pkg::SampleWidth-1:0]   req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: duty[9:0], mode[11:10], zero padding[15:12].
   output logic [15:0]                         rsp_tdata,
   input  logic                                csr_wen,
   input  logic [bbpid_pkg::CsrAddrWidth-1:0]  csr_addr,
   input  logic [bbpid_pkg::CsrDataWidth-1:0]  csr_wdata
);
   import bbpid_pkg::*;

   logic signed [SampleWidth-1:0] setpoint_ff;
   logic [CoefWidth-1:0]          coef_current_ff;
   logic [CoefWidth-1:0]          coef_last_ff;
   logic [CoefWidth-1:0]          coef_before_ff;
   logic [CoefWidth-1:0]          band_ff;

   logic signed [SampleWidth-1:0] sample_ff;
   logic                          stage_valid_ff;
   logic                          advance;

   duty_type                      duty_held_ff;
   duty_type                      duty_held_in;
   logic signed [HistWidth-1:0]   last_error_ff;
   logic signed [HistWidth-1:0]   error_before_ff;

   duty_type                      rsp_duty_ff;
   logic [ModeWidth-1:0]          rsp_mode_ff;
   logic [ModeWidth-1:0]          mode_in;
   logic                          rsp_valid_ff;

   logic signed [ErrWidth-1:0]    err;
   logic signed [ErrWidth-1:0]    band_s;
   logic signed [HistWidth-1:0]   err_hist;
   logic signed [ProdWidth-1:0]   prod_current;
   logic signed [ProdWidth-1:0]   prod_last;
   logic signed [ProdWidth-1:0]   prod_before;
   logic signed [SumWidth-1:0]    sum;
   logic                          above_band;
   logic                          below_band;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= '0;
         coef_current_ff <= RST_COEF_CURRENT;
         coef_last_ff    <= RST_COEF_LAST;
         coef_before_ff  <= RST_COEF_BEFORE;
         band_ff         <= RST_BAND;
      end else if (csr_wen) begin
         unique case (csr_addr)
            CSR_SETPOINT:     setpoint_ff     <= csr_wdata;
            CSR_COEF_CURRENT: coef_current_ff <= csr_wdata[CoefWidth-1:0];
            CSR_COEF_LAST:    coef_last_ff    <= csr_wdata[CoefWidth-1:0];
            CSR_COEF_BEFORE:  coef_before_ff  <= csr_wdata[CoefWidth-1:0];
            CSR_BAND:         band_ff         <= csr_wdata[CoefWidth-1:0];
            default: ;
         endcase
      end
   end

   assign advance    = stage_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         sample_ff <= req_tdata;
      end
   end

   assign err        = {setpoint_ff[SampleWidth-1], setpoint_ff}
                     - {sample_ff[SampleWidth-1], sample_ff};
   assign band_s     = {{(ErrWidth-CoefWidth){1'b0}}, band_ff};
   assign above_band = err > band_s;
   assign below_band = err < -band_s;
   assign err_hist   = err[HistWidth-1:0];

   assign prod_current = $signed({1'b0, coef_current_ff}) * err_hist;
   assign prod_last    = $signed({1'b0, coef_last_ff}) * last_error_ff;
   assign prod_before  = $signed({1'b0, coef_before_ff}) * error_before_ff;

   assign sum = {{(SumWidth-DutyWidth){1'b0}}, duty_held_ff}
              + {{(SumWidth-ProdWidth){prod_current[ProdWidth-1]}}, prod_current}
              - {{(SumWidth-ProdWidth){prod_last[ProdWidth-1]}}, prod_last}
              + {{(SumWidth-ProdWidth){prod_before[ProdWidth-1]}}, prod_before};

   always_comb begin
      if (above_band) begin
         duty_held_in = DUTY_MAX;
         mode_in      = MODE_FULL_ON;
      end else if (below_band) begin
         duty_held_in = '0;
         mode_in      = MODE_FULL_OFF;
      end else begin
         mode_in = MODE_PID;
         if (sum[SumWidth-1]) begin
            duty_held_in = '0;
         end else if (sum > SumWidth'(DUTY_MAX)) begin
            duty_held_in = DUTY_MAX;
         end else begin
            duty_held_in = sum[DutyWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_held_ff    <= '0;
         last_error_ff   <= '0;
         error_before_ff <= '0;
      end else if (advance) begin
         duty_held_ff <= duty_held_in;
         if (!above_band && !below_band) begin
            error_before_ff <= last_error_ff;
            last_error_ff   <= err_hist;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_duty_ff <= duty_held_in;
         rsp_mode_ff <= mode_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_mode_ff, rsp_duty_ff};

endmodule
